/* design/triangle_span_rasterizer_core_macros.svh */
// Assertion macros for the triangle span rasterizer checker.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef TRIANGLE_SPAN_RASTERIZER_CORE_MACROS_SVH
`define TRIANGLE_SPAN_RASTERIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/trs_pkg.sv */
// ---------------------------------------------------------------------------
// trs_pkg
// Shared types and constants of the triangle span rasterizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W      = 32;
    localparam int ROW_OUT_W    = 6;
    localparam int COL_OUT_W    = 10;
    localparam int TOTAL_W      = 17;
    localparam int COLS_REG_W   = 11;
    localparam int ROWS_REG_W   = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 6 * COORD_W;
    localparam int OUT_FIELDS_W = ROW_OUT_W + 2 * COL_OUT_W + TOTAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TOTAL_LSB = ROW_OUT_W + 2 * COL_OUT_W;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_INV_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_INV_PITCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd5;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_CROSS,
        BE_WAIT_A,
        BE_START_B,
        BE_WAIT_B,
        BE_MERGE,
        BE_ROW,
        BE_DONE
    } be_state_t;

    typedef enum logic [2:0] {
        ED_IDLE,
        ED_MUL,
        ED_LOAD,
        ED_DIV,
        ED_DONE
    } ed_state_t;

    // Status of the edge crossing unit
    typedef struct packed {
        logic busy;
        logic done;
    } edge_status_t;

endpackage

`default_nettype wire

/* design/triangle_span_rasterizer_core.sv */
// ---------------------------------------------------------------------------
// triangle_span_rasterizer_core
// Conservative scanline rasterizer: one triangle in, at most one span per row out.
// ---------------------------------------------------------------------------
// Channel   Direction  Beat contents
// cfg       in         cfg_wr_en, cfg_index, cfg_data (write only)
// s_axis    in         one triangle: three Q16.16 vertices
// m_axis    out        one span request; tlast on the triangle's last one
//
// Setup in the front uses one shared 33x32 multiplier for the six coordinates;
// the job queue holds two triangles for the back.
// Each edge crossing forms four partial products in the edge unit, then one
// quotient bit a cycle; a row costs two crossings and the first line two more.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds the back at its next span; the front keeps working until the job queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_span_rasterizer_core #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [trs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y
    input  logic [trs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // span_row, span_first, span_end, pixel_total, zero pad
    output logic [trs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // no_pixels
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import trs_pkg::*;

    localparam int PX_W   = 33 + FRAC_BITS;
    localparam int JOB_W  = 6 * PX_W + 1;
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int NCOL_W = $clog2(MAX_COLUMNS + 1);

    logic [COORD_W-1:0]    x_origin_reg, y_origin_reg, x_inv_pitch_reg, y_inv_pitch_reg;
    logic [COLS_REG_W-1:0] grid_columns_reg;
    logic [ROWS_REG_W-1:0] grid_rows_reg;

    logic [NCOL_W-1:0]     ncol;
    logic [ROW_W-1:0]      nrow;

    logic                  fe_valid, q_full, q_pop, q_valid;
    logic [JOB_W-1:0]      fe_data, q_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            x_inv_pitch_reg  <= 32'h0001_0000;
            y_inv_pitch_reg  <= 32'h0001_0000;
            grid_columns_reg <= 11'd1024;
            grid_rows_reg    <= 7'd64;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_X_ORIGIN:     x_origin_reg     <= cfg_data;
                REG_Y_ORIGIN:     y_origin_reg     <= cfg_data;
                REG_X_INV_PITCH:  x_inv_pitch_reg  <= cfg_data;
                REG_Y_INV_PITCH:  y_inv_pitch_reg  <= cfg_data;
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data[COLS_REG_W-1:0];
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data[ROWS_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // grid size, zero taken as one and clamped to the maximum
    always_comb
    begin
        if (grid_columns_reg == '0)
            ncol = NCOL_W'(1);
        else if (32'(grid_columns_reg) > 32'(MAX_COLUMNS))
            ncol = NCOL_W'(MAX_COLUMNS);
        else
            ncol = NCOL_W'(grid_columns_reg);
        if (grid_rows_reg == '0)
            nrow = ROW_W'(1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            nrow = ROW_W'(MAX_ROWS);
        else
            nrow = ROW_W'(grid_rows_reg);
    end

    trs_front #(
        .FRAC_BITS (FRAC_BITS),
        .ROW_W     (ROW_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_tvalid   (s_axis_tvalid),
        .in_tready   (s_axis_tready),
        .in_tdata    (s_axis_tdata),
        .x_origin    (x_origin_reg),
        .y_origin    (y_origin_reg),
        .x_inv_pitch (x_inv_pitch_reg),
        .y_inv_pitch (y_inv_pitch_reg),
        .nrow        (nrow),
        .job_valid   (fe_valid),
        .job_full    (q_full),
        .job_data    (fe_data)
    );

    trs_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fe_valid),
        .wr_data   (fe_data),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_data),
        .not_empty (q_valid)
    );

    trs_back #(
        .FRAC_BITS (FRAC_BITS),
        .ROW_W     (ROW_W),
        .NCOL_W    (NCOL_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job_pop    (q_pop),
        .job_data   (q_data),
        .ncol       (ncol),
        .nrow       (nrow),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser),
        .out_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* design/trs_fifo.sv */
// ---------------------------------------------------------------------------
// trs_fifo
// Short job queue that decouples the setup front from the span back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    import trs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en && not_empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((wr_en && !full) && !(rd_en && not_empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(wr_en && !full) && (rd_en && not_empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/trs_front.sv */
// ---------------------------------------------------------------------------
// trs_front
// Accepts a triangle, sorts it by y, maps it to pixel space and queues it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_front #(
    parameter int FRAC_BITS = 16,
    parameter int ROW_W     = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_tvalid,
    output logic                                in_tready,
    input  logic [trs_pkg::IN_TDATA_W-1:0]      in_tdata,
    input  logic [trs_pkg::COORD_W-1:0]         x_origin,
    input  logic [trs_pkg::COORD_W-1:0]         y_origin,
    input  logic [trs_pkg::COORD_W-1:0]         x_inv_pitch,
    input  logic [trs_pkg::COORD_W-1:0]         y_inv_pitch,
    input  logic [ROW_W-1:0]                    nrow,
    output logic                                job_valid,
    input  logic                                job_full,
    output logic [6*(33+FRAC_BITS):0]           job_data
);
    import trs_pkg::*;

    localparam int PX_W  = 33 + FRAC_BITS;
    localparam int SHIFT = 32 - FRAC_BITS;

    fe_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] vx_reg [3];
    logic signed [COORD_W-1:0] vy_reg [3];
    logic signed [PX_W-1:0]    coord_reg [6];
    logic [2:0]                cnt_reg;
    logic [64:0]               prod_reg;
    logic                      neg_reg;

    logic signed [COORD_W-1:0] wy0, wy1, wy2;
    logic [1:0]                ord [3];
    logic                      accept;

    logic signed [COORD_W-1:0] sel_v, sel_org;
    logic [COORD_W-1:0]        sel_pitch;
    logic signed [32:0]        diff;
    logic [32:0]               mag;
    logic [PX_W-1:0]           m_val;
    logic [2:0]                prev;
    logic signed [PX_W-1:0]    rowmax;
    logic                      reject;

    assign accept = in_tvalid && in_tready;
    assign wy0 = in_tdata[1*COORD_W +: COORD_W];
    assign wy1 = in_tdata[3*COORD_W +: COORD_W];
    assign wy2 = in_tdata[5*COORD_W +: COORD_W];

    // sorting network on world y
    always_comb
    begin
        if (wy0 < wy1)
        begin
            if (wy1 < wy2)      begin ord[0] = 2'd0; ord[1] = 2'd1; ord[2] = 2'd2; end
            else if (wy0 < wy2) begin ord[0] = 2'd0; ord[1] = 2'd2; ord[2] = 2'd1; end
            else                begin ord[0] = 2'd2; ord[1] = 2'd0; ord[2] = 2'd1; end
        end
        else
        begin
            if (wy2 < wy1)      begin ord[0] = 2'd2; ord[1] = 2'd1; ord[2] = 2'd0; end
            else if (wy0 < wy2) begin ord[0] = 2'd1; ord[1] = 2'd0; ord[2] = 2'd2; end
            else                begin ord[0] = 2'd1; ord[1] = 2'd2; ord[2] = 2'd0; end
        end
    end

    // operand of the shared conversion multiplier
    always_comb
    begin
        case (cnt_reg)
            3'd0:    sel_v = vx_reg[0];
            3'd1:    sel_v = vy_reg[0];
            3'd2:    sel_v = vx_reg[1];
            3'd3:    sel_v = vy_reg[1];
            3'd4:    sel_v = vx_reg[2];
            3'd5:    sel_v = vy_reg[2];
            default: sel_v = '0;
        endcase
        sel_org   = cnt_reg[0] ? $signed(y_origin) : $signed(x_origin);
        sel_pitch = cnt_reg[0] ? y_inv_pitch : x_inv_pitch;
        diff      = {sel_v[COORD_W-1], sel_v} - {sel_org[COORD_W-1], sel_org};
        mag       = diff[32] ? 33'(-diff) : 33'(diff);
    end

    // truncate magnitude, then apply sign
    assign m_val  = PX_W'(prod_reg >> SHIFT);
    assign prev   = cnt_reg - 3'd1;
    assign rowmax = $signed(PX_W'(nrow) << FRAC_BITS);
    assign reject = (coord_reg[1] >= rowmax) || (coord_reg[5] < 0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: if (accept) state_next = FE_CONV;
            FE_CONV: if (cnt_reg == 3'd6) state_next = FE_PUSH;
            FE_PUSH: if (!job_full) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_tready = (state_reg == FE_IDLE);
        job_valid = (state_reg == FE_PUSH);
        job_data  = {reject, coord_reg[5], coord_reg[3], coord_reg[1],
                     coord_reg[4], coord_reg[2], coord_reg[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == FE_CONV)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // payload: sorted vertices, products and pixel coordinates
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vx_reg[k] <= in_tdata[(2*ord[k])*COORD_W +: COORD_W];
                vy_reg[k] <= in_tdata[(2*ord[k]+1)*COORD_W +: COORD_W];
            end
        end
        if (state_reg == FE_CONV)
        begin
            if (cnt_reg < 3'd6)
            begin
                prod_reg <= 65'(mag) * 65'(sel_pitch);
                neg_reg  <= diff[32];
            end
            if (cnt_reg != 3'd0)
            begin
                coord_reg[prev] <= neg_reg ? $signed(-m_val) : $signed(m_val);
            end
        end
    end

endmodule

`default_nettype wire

/* design/trs_edge.sv */
// ---------------------------------------------------------------------------
// trs_edge
// Edge crossing unit: xa + (y - ya) * (xb - xa) / (yb - ya), sequential.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_edge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [32+FRAC_BITS:0] y,
    input  logic signed [32+FRAC_BITS:0] xa,
    input  logic signed [32+FRAC_BITS:0] ya,
    input  logic signed [32+FRAC_BITS:0] xb,
    input  logic signed [32+FRAC_BITS:0] yb,
    output logic signed [32+FRAC_BITS:0] x,
    output trs_pkg::edge_status_t      status
);
    import trs_pkg::*;

    localparam int PX_W  = 33 + FRAC_BITS;
    localparam int DW    = PX_W;
    localparam int H     = (DW + 1) / 2;
    localparam int ACC_W = 4 * H;
    localparam int CNT_W = $clog2(DW + 1);

    ed_state_t state_reg, state_next;

    logic [2:0]             mcnt_reg;
    logic [CNT_W-1:0]       dcnt_reg;
    logic                   neg_reg;
    logic signed [PX_W-1:0] xa_reg;
    logic [DW-1:0]          mag_reg, ny_reg, den_reg;
    logic [2*H-1:0]         pp_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [DW-1:0]          rem_reg, num_reg, q_reg;

    logic signed [PX_W:0]   dx;
    logic [H-1:0]           opa, opb;
    logic [2:0]             prev;
    logic [ACC_W-1:0]       pp_shifted;
    logic [DW:0]            trial;
    logic                   fits;

    assign dx = {xb[PX_W-1], xb} - {xa[PX_W-1], xa};

    // partial products of the split operands
    always_comb
    begin
        opa        = mcnt_reg[0] ? H'(mag_reg >> H) : mag_reg[H-1:0];
        opb        = mcnt_reg[1] ? H'(ny_reg >> H) : ny_reg[H-1:0];
        prev       = mcnt_reg - 3'd1;
        pp_shifted = ACC_W'(pp_reg) << ((int'(prev[0]) + int'(prev[1])) * H);
        trial      = {rem_reg, num_reg[DW-1]};
        fits       = (trial >= {1'b0, den_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ED_IDLE: if (start) state_next = (xa == xb) ? ED_DONE : ED_MUL;
            ED_MUL:  if (mcnt_reg == 3'd4) state_next = ED_LOAD;
            ED_LOAD: state_next = ED_DIV;
            ED_DIV:  if (dcnt_reg == CNT_W'(DW - 1)) state_next = ED_DONE;
            ED_DONE: state_next = ED_IDLE;
            default: state_next = ED_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        status.busy = (state_reg != ED_IDLE);
        status.done = (state_reg == ED_DONE);
        x = neg_reg ? xa_reg - $signed(q_reg) : xa_reg + $signed(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ED_IDLE;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ED_IDLE)
            begin
                mcnt_reg <= '0;
            end
            else if (state_reg == ED_MUL)
            begin
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            if (state_reg == ED_LOAD)
            begin
                dcnt_reg <= '0;
            end
            else if (state_reg == ED_DIV)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ED_IDLE:
            begin
                if (start)
                begin
                    xa_reg  <= xa;
                    neg_reg <= (xa != xb) && dx[PX_W];
                    mag_reg <= dx[PX_W] ? DW'(-dx) : DW'(dx);
                    ny_reg  <= DW'(y - ya);
                    den_reg <= DW'(yb - ya);
                    acc_reg <= '0;
                    q_reg   <= '0;
                end
            end
            ED_MUL:
            begin
                if (mcnt_reg < 3'd4)
                begin
                    pp_reg <= (2*H)'(opa) * (2*H)'(opb);
                end
                if (mcnt_reg != 3'd0)
                begin
                    acc_reg <= acc_reg + pp_shifted;
                end
            end
            ED_LOAD:
            begin
                // quotient is narrower than DW, so the upper half is below the divisor
                rem_reg <= acc_reg[2*DW-1:DW];
                num_reg <= acc_reg[DW-1:0];
            end
            ED_DIV:
            begin
                rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
                q_reg   <= {q_reg[DW-2:0], fits};
                num_reg <= {num_reg[DW-2:0], 1'b0};
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/trs_back.sv */
// ---------------------------------------------------------------------------
// trs_back
// Walks the rows of one queued triangle and delivers its spans.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_back #(
    parameter int FRAC_BITS = 16,
    parameter int ROW_W     = 7,
    parameter int NCOL_W    = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    output logic                               job_pop,
    input  logic [6*(33+FRAC_BITS):0]          job_data,
    input  logic [NCOL_W-1:0]                  ncol,
    input  logic [ROW_W-1:0]                   nrow,
    output logic                               out_tvalid,
    input  logic                               out_tready,
    output logic [trs_pkg::OUT_TDATA_W-1:0]    out_tdata,
    output logic [0:0]                         out_tuser,
    output logic                               out_tlast
);
    import trs_pkg::*;

    localparam int PX_W = 33 + FRAC_BITS;

    be_state_t state_reg, state_next;

    logic signed [PX_W-1:0] px_reg [3];
    logic signed [PX_W-1:0] py_reg [3];
    logic [ROW_W-1:0]       iy_reg, iylast_reg;
    logic signed [PX_W-1:0] line_reg;
    logic                   phase_hi_reg;
    logic                   lo_v_reg, hi_v_reg;
    logic signed [PX_W-1:0] lo0_reg, lo1_reg, hi0_reg, hi1_reg, a_reg;
    logic                   held_v_reg;
    logic [ROW_OUT_W-1:0]   held_row_reg;
    logic [COL_OUT_W-1:0]   held_c0_reg, held_c1_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   out_valid_reg, out_last_reg, out_empty_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic signed [PX_W-1:0] j_px [3];
    logic signed [PX_W-1:0] j_py [3];
    logic                   j_reject;
    logic signed [PX_W-1:0] j_vrow0, j_vrow2, nrow_s;

    logic signed [PX_W-1:0] ed_xa, ed_ya, ed_xb, ed_yb, ed_x;
    edge_status_t           ed_status;
    logic                   ed_start;
    logic                   cross_ok;

    logic                   m_v;
    logic signed [PX_W-1:0] m0, m1;
    logic signed [PX_W-1:0] b_lo, b_hi;

    logic signed [PX_W-1:0] colmax, r0, r1;
    logic                   emit;
    logic [TOTAL_W-1:0]     c0, c1, span_cnt;
    logic                   push_ok, push, row_go;

    // unpack the queued job
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            j_px[k] = job_data[k*PX_W +: PX_W];
            j_py[k] = job_data[(3+k)*PX_W +: PX_W];
        end
        j_reject = job_data[6*PX_W];
        j_vrow0  = j_py[0] >>> FRAC_BITS;
        j_vrow2  = j_py[2] >>> FRAC_BITS;
        nrow_s   = $signed(PX_W'(nrow));
    end

    // line strictly between lowest and highest vertex
    assign cross_ok = (py_reg[0] < line_reg) && (line_reg < py_reg[2]);

    // edge operands: long edge first, then the short edge the line meets
    always_comb
    begin
        if (state_reg == BE_START_B)
        begin
            if (line_reg < py_reg[1])
            begin
                ed_xa = px_reg[0]; ed_ya = py_reg[0]; ed_xb = px_reg[1]; ed_yb = py_reg[1];
            end
            else
            begin
                ed_xa = px_reg[1]; ed_ya = py_reg[1]; ed_xb = px_reg[2]; ed_yb = py_reg[2];
            end
        end
        else
        begin
            ed_xa = px_reg[0]; ed_ya = py_reg[0]; ed_xb = px_reg[2]; ed_yb = py_reg[2];
        end
    end

    trs_edge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ed_start),
        .y      (line_reg),
        .xa     (ed_xa),
        .ya     (ed_ya),
        .xb     (ed_xb),
        .yb     (ed_yb),
        .x      (ed_x),
        .status (ed_status)
    );

    assign b_lo = (ed_x < a_reg) ? ed_x : a_reg;
    assign b_hi = (ed_x < a_reg) ? a_reg : ed_x;

    // widen the lower-line range by vertices inside the current row
    always_comb
    begin
        m_v = lo_v_reg;
        m0  = lo0_reg;
        m1  = lo1_reg;
        for (int k = 0; k < 3; k++)
        begin
            if ((py_reg[k] >>> FRAC_BITS) == $signed(PX_W'(iy_reg)))
            begin
                if (!m_v)
                begin
                    m0  = px_reg[k];
                    m1  = px_reg[k];
                    m_v = 1'b1;
                end
                else
                begin
                    if (px_reg[k] < m0) m0 = px_reg[k];
                    if (px_reg[k] > m1) m1 = px_reg[k];
                end
            end
        end
    end

    // span of the current row, clipped to the grid
    always_comb
    begin
        colmax = $signed(PX_W'(ncol) << FRAC_BITS);
        if (lo_v_reg && hi_v_reg)
        begin
            r0 = (lo0_reg < hi0_reg) ? lo0_reg : hi0_reg;
            r1 = (lo1_reg > hi1_reg) ? lo1_reg : hi1_reg;
        end
        else if (lo_v_reg)
        begin
            r0 = lo0_reg; r1 = lo1_reg;
        end
        else
        begin
            r0 = hi0_reg; r1 = hi1_reg;
        end
        emit     = (lo_v_reg || hi_v_reg) && (r1 >= 0) && (r0 < colmax);
        c0       = (r0 < 0) ? '0 : TOTAL_W'(r0 >>> FRAC_BITS);
        c1       = (r1 >= colmax) ? TOTAL_W'(ncol) - 1'b1 : TOTAL_W'(r1 >>> FRAC_BITS);
        span_cnt = c1 - c0 + 1'b1;
    end

    assign push_ok = !out_valid_reg || out_tready;
    assign row_go  = (state_reg == BE_ROW) && !(emit && held_v_reg && !push_ok);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE:    if (job_valid) state_next = j_reject ? BE_DONE : BE_CROSS;
            BE_CROSS:   state_next = cross_ok ? BE_WAIT_A : (phase_hi_reg ? BE_ROW : BE_MERGE);
            BE_WAIT_A:  if (ed_status.done) state_next = BE_START_B;
            BE_START_B: state_next = BE_WAIT_B;
            BE_WAIT_B:  if (ed_status.done) state_next = phase_hi_reg ? BE_ROW : BE_MERGE;
            BE_MERGE:   state_next = BE_CROSS;
            BE_ROW:     if (row_go) state_next = (iy_reg == iylast_reg) ? BE_DONE : BE_MERGE;
            BE_DONE:    if (push_ok) state_next = BE_IDLE;
            default:    state_next = BE_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        job_pop  = (state_reg == BE_IDLE) && job_valid;
        ed_start = ((state_reg == BE_CROSS) && cross_ok) || (state_reg == BE_START_B);
        push     = (row_go && emit && held_v_reg) || ((state_reg == BE_DONE) && push_ok);
        out_tvalid   = out_valid_reg;
        out_tdata    = out_data_reg;
        out_tuser[0] = out_empty_reg;
        out_tlast    = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            held_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop || ((state_reg == BE_DONE) && push_ok))
            begin
                held_v_reg <= 1'b0;
            end
            else if (row_go && emit)
            begin
                held_v_reg <= 1'b1;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // row walk datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BE_IDLE:
            begin
                if (job_valid)
                begin
                    px_reg       <= j_px;
                    py_reg       <= j_py;
                    iy_reg       <= (j_vrow0 < 0) ? '0 : ROW_W'(j_vrow0);
                    iylast_reg   <= (j_vrow2 >= nrow_s) ? nrow - 1'b1 : ROW_W'(j_vrow2);
                    line_reg     <= (j_vrow0 < 0) ? '0 :
                                    $signed(PX_W'(ROW_W'(j_vrow0)) << FRAC_BITS);
                    phase_hi_reg <= 1'b0;
                    total_reg    <= '0;
                end
            end
            BE_CROSS:
            begin
                if (!cross_ok)
                begin
                    if (phase_hi_reg) hi_v_reg <= 1'b0;
                    else              lo_v_reg <= 1'b0;
                end
            end
            BE_WAIT_A:
            begin
                if (ed_status.done) a_reg <= ed_x;
            end
            BE_WAIT_B:
            begin
                if (ed_status.done)
                begin
                    if (phase_hi_reg)
                    begin
                        hi_v_reg <= 1'b1; hi0_reg <= b_lo; hi1_reg <= b_hi;
                    end
                    else
                    begin
                        lo_v_reg <= 1'b1; lo0_reg <= b_lo; lo1_reg <= b_hi;
                    end
                end
            end
            BE_MERGE:
            begin
                lo_v_reg     <= m_v;
                lo0_reg      <= m0;
                lo1_reg      <= m1;
                line_reg     <= $signed((PX_W'(iy_reg) + 1'b1) << FRAC_BITS);
                phase_hi_reg <= 1'b1;
            end
            BE_ROW:
            begin
                if (row_go)
                begin
                    if (emit)
                    begin
                        held_row_reg <= ROW_OUT_W'(iy_reg);
                        held_c0_reg  <= COL_OUT_W'(c0);
                        held_c1_reg  <= COL_OUT_W'(c1);
                        total_reg    <= total_reg + span_cnt;
                    end
                    lo_v_reg <= hi_v_reg;
                    lo0_reg  <= hi0_reg;
                    lo1_reg  <= hi1_reg;
                    if (iy_reg != iylast_reg) iy_reg <= iy_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // output register: earlier span on a row, last span or empty mark at the end
        if (push)
        begin
            if (state_reg == BE_DONE && held_v_reg)
            begin
                out_data_reg  <= OUT_TDATA_W'({total_reg, held_c1_reg, held_c0_reg,
                                               held_row_reg});
                out_last_reg  <= 1'b1;
                out_empty_reg <= 1'b0;
            end
            else if (state_reg == BE_DONE)
            begin
                out_data_reg  <= '0;
                out_last_reg  <= 1'b1;
                out_empty_reg <= 1'b1;
            end
            else
            begin
                out_data_reg  <= OUT_TDATA_W'({held_c1_reg, held_c0_reg, held_row_reg});
                out_last_reg  <= 1'b0;
                out_empty_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/trs_checker.sv */
// ---------------------------------------------------------------------------
// trs_checker
// Port-level checks of the triangle span rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_span_rasterizer_core_macros.svh"

module trs_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [trs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [0:0]                      m_axis_tuser,
    input  logic                            m_axis_tlast
);
    import trs_pkg::*;

    // an empty triangle gives a single, all-zero, last result
    `TRS_ASSERT_NOW(a_empty_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == '0), "empty result not last or not zero")

    // the pixel total appears only on the last span
    `TRS_ASSERT_NOW(a_total_on_last, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[OUT_TDATA_W-1:OUT_TOTAL_LSB] == '0, "pixel total on a non-final span")

    // a stalled result holds
    `TRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // the front is busy converting right after it takes a triangle
    `TRS_ASSERT_NEXT(a_front_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "front ready during setup")

endmodule

bind triangle_span_rasterizer_core trs_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
